FILE: rtl/rgb_led_strip_serializer_macros.svh
// ----------------------------------------------------------------------------
// RGB LED strip serializer - assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_STRIP_SERIALIZER_MACROS_SVH
`define RGB_LED_STRIP_SERIALIZER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RLSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rlss: assertion failed");

// condition must never be seen outside reset
`define RLSS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rlss: forbidden condition seen");

`else

`define RLSS_ASSERT(label, clk, rst_n, prop)
`define RLSS_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/rlss_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED strip serializer - package
// Shared constants, register indices and types.
// ----------------------------------------------------------------------------
package rlss_pkg;

    localparam int SYMBOLS_PER_LED   = 24;
    localparam int CNT_W             = 5;
    localparam int DEFAULT_LED_SLOTS = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_IDX_W         = 3;

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_POS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd4;

    // register reset values
    localparam logic [7:0] RST_BRIGHTNESS = 8'd255;
    localparam logic [7:0] RST_SWAP_POS   = 8'd1;
    localparam logic [7:0] RST_ZERO_HIGH  = 8'd8;
    localparam logic [7:0] RST_ONE_HIGH   = 8'd16;
    localparam logic [7:0] RST_BIT_PERIOD = 8'd25;

    // one LED after scaling and swap, waiting for serialisation
    typedef struct packed {
        logic [23:0] word;
        logic        frame_end;
    } rlss_entry_t;

    // symbol timing registers
    typedef struct packed {
        logic [7:0] zero_high;
        logic [7:0] one_high;
        logic [7:0] period;
    } rlss_timing_t;

endpackage

FILE: rtl/rlss_front.sv
// ----------------------------------------------------------------------------
// RGB LED strip serializer - front end
// Scales colours, swaps red/green at one position, tracks LED position.
// ----------------------------------------------------------------------------
module rlss_front #(
    parameter int LED_SLOTS = rlss_pkg::DEFAULT_LED_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  frame_end,
    input  logic [7:0]            brightness,
    input  logic [7:0]            swap_position,
    input  logic                  q_full,
    output logic                  q_push,
    output rlss_pkg::rlss_entry_t q_entry
);
    import rlss_pkg::*;

    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    logic [7:0]  sc_r;
    logic [7:0]  sc_g;
    logic [7:0]  sc_b;
    logic        swap;
    logic [8:0]  pos_inc;

    assign q_push = push && !q_full;

    // (c * b) >> 8
    assign prod_r = {8'd0, red} * {8'd0, brightness};
    assign prod_g = {8'd0, green} * {8'd0, brightness};
    assign prod_b = {8'd0, blue} * {8'd0, brightness};
    assign sc_r   = prod_r[15:8];
    assign sc_g   = prod_g[15:8];
    assign sc_b   = prod_b[15:8];

    assign swap = (pos_reg == swap_position);

    always_comb
    begin
        q_entry.frame_end = frame_end;
        if (swap)
        begin
            q_entry.word = {sc_g, sc_r, sc_b};
        end
        else
        begin
            q_entry.word = {sc_r, sc_g, sc_b};
        end
    end

    assign pos_inc = {1'b0, pos_reg} + 9'd1;

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (frame_end || (pos_inc >= 9'(LED_SLOTS)))
            begin
                pos_next = 8'd0;
            end
            else
            begin
                pos_next = pos_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/rlss_queue.sv
// ----------------------------------------------------------------------------
// RGB LED strip serializer - item queue
// Short FIFO between the front end and the bit serialiser.
// ----------------------------------------------------------------------------
module rlss_queue #(
    parameter int DEPTH = rlss_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  rlss_pkg::rlss_entry_t wr_data,
    input  logic                  rd_en,
    output rlss_pkg::rlss_entry_t rd_data,
    output logic                  full,
    output logic                  empty
);
    import rlss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    rlss_entry_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/rlss_back.sv
// ----------------------------------------------------------------------------
// RGB LED strip serializer - back end
// Shifts each 24-bit word out as pulse symbols into an output register.
// ----------------------------------------------------------------------------
`include "rgb_led_strip_serializer_macros.svh"

module rlss_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  rlss_pkg::rlss_entry_t  q_entry,
    output logic                   q_pop,
    input  rlss_pkg::rlss_timing_t timing,
    input  logic                   pop,
    output logic                   empty,
    output logic                   bit_value,
    output logic [7:0]             high_ticks,
    output logic [7:0]             low_ticks,
    output logic                   last_of_led,
    output logic                   frame_done
);
    import rlss_pkg::*;

    localparam logic [CNT_W-1:0] LAST_SYM = CNT_W'(SYMBOLS_PER_LED - 1);

    logic             busy_reg;
    logic             busy_next;
    logic [23:0]      word_reg;
    logic [23:0]      word_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             fend_reg;
    logic             fend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_bit_reg;
    logic [7:0]       out_hi_reg;
    logic [7:0]       out_lo_reg;
    logic             out_last_reg;
    logic             out_fdone_reg;
    logic             out_free;
    logic             emit;
    logic             emit_last;
    logic             load;
    logic             sym_bit;
    logic [7:0]       sym_hi;
    logic [7:0]       sym_lo;

    assign out_free  = !out_valid_reg || pop;
    assign emit      = busy_reg && out_free;
    assign emit_last = emit && (cnt_reg == LAST_SYM);
    assign load      = !q_empty && (!busy_reg || emit_last);
    assign q_pop     = load;

    // symbol timing, low part saturates at zero
    assign sym_bit = word_reg[23];
    assign sym_hi  = sym_bit ? timing.one_high : timing.zero_high;
    assign sym_lo  = (timing.period > sym_hi) ? (timing.period - sym_hi) : 8'd0;

    always_comb
    begin
        busy_next      = busy_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        fend_next      = fend_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            word_next      = {word_reg[22:0], 1'b0};
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            if (emit_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            word_next = q_entry.word;
            cnt_next  = '0;
            fend_next = q_entry.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        fend_reg <= fend_next;
        if (emit)
        begin
            out_bit_reg   <= sym_bit;
            out_hi_reg    <= sym_hi;
            out_lo_reg    <= sym_lo;
            out_last_reg  <= emit_last;
            out_fdone_reg <= emit_last && fend_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign bit_value   = out_bit_reg;
    assign high_ticks  = out_hi_reg;
    assign low_ticks   = out_lo_reg;
    assign last_of_led = out_last_reg;
    assign frame_done  = out_fdone_reg;

    `RLSS_NEVER(a_cnt_range, clk, rst_n, busy_reg && (cnt_reg > LAST_SYM))
    `RLSS_ASSERT(a_last_follows, clk, rst_n, emit_last |=> (out_valid_reg && out_last_reg))
    `RLSS_ASSERT(a_fdone_on_last, clk, rst_n,
                 (out_valid_reg && out_fdone_reg) |-> out_last_reg)
    `RLSS_NEVER(a_load_mid_led, clk, rst_n, load && busy_reg && !emit_last)

endmodule

FILE: rtl/rgb_led_strip_serializer.sv
// ----------------------------------------------------------------------------
// RGB LED strip serializer - top level
// One LED colour in, 24 timed pulse symbols out, with brightness and swap.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ----------------------------------
//  input     in         push / full             red, green, blue, frame_end
//  result    out        pop / empty             bit_value, high_ticks, low_ticks,
//                                               last_of_led, frame_done
//  config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Each item yields 24 symbols. The serialiser delivers at most one symbol a
//  cycle, one every cycle while pop stays high; in use the consumer's bit
//  timing sets the pace. The front end takes an item in any cycle the
//  two-entry queue has room, including while a finished symbol waits in
//  the output register.
//  Reset is asynchronous and active low; registers return to their defaults,
//  the LED position to zero. No clearing pass. cfg_ready is always high.
//
`include "rgb_led_strip_serializer_macros.svh"

module rgb_led_strip_serializer #(
    parameter int LED_SLOTS = rlss_pkg::DEFAULT_LED_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input item queue side
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    input  logic                             frame_end,
    // result queue side
    input  logic                             pop,
    output logic                             empty,
    output logic                             bit_value,
    output logic [7:0]                       high_ticks,
    output logic [7:0]                       low_ticks,
    output logic                             last_of_led,
    output logic                             frame_done,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data
);
    import rlss_pkg::*;

    logic [7:0]   brightness_reg;
    logic [7:0]   swap_pos_reg;
    logic [7:0]   zero_high_reg;
    logic [7:0]   one_high_reg;
    logic [7:0]   period_reg;
    logic         cfg_wr;
    rlss_timing_t timing;
    rlss_entry_t  fe_entry;
    rlss_entry_t  q_entry;
    logic         fe_push;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file; unknown indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= RST_BRIGHTNESS;
            swap_pos_reg   <= RST_SWAP_POS;
            zero_high_reg  <= RST_ZERO_HIGH;
            one_high_reg   <= RST_ONE_HIGH;
            period_reg     <= RST_BIT_PERIOD;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_data;
                REG_SWAP_POS:   swap_pos_reg   <= cfg_data;
                REG_ZERO_HIGH:  zero_high_reg  <= cfg_data;
                REG_ONE_HIGH:   one_high_reg   <= cfg_data;
                REG_BIT_PERIOD: period_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign timing.zero_high = zero_high_reg;
    assign timing.one_high  = one_high_reg;
    assign timing.period    = period_reg;

    assign full = q_full;

    // front end: scale, swap, position
    rlss_front #(
        .LED_SLOTS(LED_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_end    (frame_end),
        .brightness   (brightness_reg),
        .swap_position(swap_pos_reg),
        .q_full       (q_full),
        .q_push       (fe_push),
        .q_entry      (fe_entry)
    );

    // decoupling queue
    rlss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fe_push),
        .wr_data(fe_entry),
        .rd_en  (q_pop),
        .rd_data(q_entry),
        .full   (q_full),
        .empty  (q_empty)
    );

    // back end: bit serialiser with output register
    rlss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .timing     (timing),
        .pop        (pop),
        .empty      (empty),
        .bit_value  (bit_value),
        .high_ticks (high_ticks),
        .low_ticks  (low_ticks),
        .last_of_led(last_of_led),
        .frame_done (frame_done)
    );

    `RLSS_ASSERT(a_push_only_with_room, clk, rst_n, fe_push |-> !q_full)
    `RLSS_NEVER(a_no_pop_from_empty_queue, clk, rst_n, q_pop && q_empty)
    `RLSS_ASSERT(a_full_blocks_push, clk, rst_n, full |-> !fe_push)

endmodule

FILE: tb/sv/led_symbol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED symbol checker
// Watches the colour, symbol and register channels of the strip serialiser,
// works out the 24 pulse symbols each accepted LED should give, and compares
// every symbol popped with the oldest one still owed.
// ----------------------------------------------------------------------------
module led_symbol_checker #(
    parameter int SLOTS = rlss_pkg::DEFAULT_LED_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic                           frame_end,
    input  logic                           pop,
    input  logic                           empty,
    input  logic                           bit_value,
    input  logic [7:0]                     high_ticks,
    input  logic [7:0]                     low_ticks,
    input  logic                           last_of_led,
    input  logic                           frame_done,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [rlss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           closing,
    output int                             mismatches,
    output int                             symbols_owed,
    output int                             symbols_seen
);
    import rlss_pkg::*;

    typedef struct packed {
        logic       bit_value;
        logic [7:0] high_ticks;
        logic [7:0] low_ticks;
        logic       last_of_led;
        logic       frame_done;
    } led_symbol_t;

    logic [7:0]  brightness_q;
    logic [7:0]  swap_pos_q;
    logic [7:0]  zero_high_q;
    logic [7:0]  one_high_q;
    logic [7:0]  period_q;
    logic [7:0]  position_q;
    led_symbol_t owed_q[$];

    initial
    begin
        mismatches   = 0;
        symbols_owed = 0;
        symbols_seen = 0;
    end

    task automatic report(input string what);
        $display("checker: %s", what);
        mismatches++;
    endtask

    function automatic logic [7:0] scaled(input logic [7:0] c);
        logic [15:0] prod;
        prod = {8'd0, c} * {8'd0, brightness_q};
        return prod[15:8];
    endfunction

    // 24 symbols, red then green then blue (green first at the swap position), msb first
    task automatic predict_led(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic fe);
        logic [23:0] word;
        led_symbol_t sym;
        if (position_q == swap_pos_q)
            word = {scaled(g), scaled(r), scaled(b)};
        else
            word = {scaled(r), scaled(g), scaled(b)};
        for (int k = SYMBOLS_PER_LED - 1; k >= 0; k--)
        begin
            sym.bit_value   = word[k];
            sym.high_ticks  = word[k] ? one_high_q : zero_high_q;
            sym.low_ticks   = (period_q > sym.high_ticks) ? period_q - sym.high_ticks : 8'd0;
            sym.last_of_led = (k == 0);
            sym.frame_done  = (k == 0) && fe;
            owed_q.push_back(sym);
        end
        if (fe || int'(position_q) + 1 >= SLOTS)
            position_q = 8'd0;
        else
            position_q = position_q + 8'd1;
    endtask

    task automatic check_symbol();
        led_symbol_t want;
        if (owed_q.size() == 0)
        begin
            report($sformatf("symbol %0d popped with none owed", symbols_seen));
            return;
        end
        want = owed_q.pop_front();
        if (bit_value !== want.bit_value)
            report($sformatf("symbol %0d bit_value %0d, want %0d",
                             symbols_seen, bit_value, want.bit_value));
        if (high_ticks !== want.high_ticks)
            report($sformatf("symbol %0d high_ticks %0d, want %0d",
                             symbols_seen, high_ticks, want.high_ticks));
        if (low_ticks !== want.low_ticks)
            report($sformatf("symbol %0d low_ticks %0d, want %0d",
                             symbols_seen, low_ticks, want.low_ticks));
        if (last_of_led !== want.last_of_led)
            report($sformatf("symbol %0d last_of_led %0d, want %0d",
                             symbols_seen, last_of_led, want.last_of_led));
        if (frame_done !== want.frame_done)
            report($sformatf("symbol %0d frame_done %0d, want %0d",
                             symbols_seen, frame_done, want.frame_done));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_q = RST_BRIGHTNESS;
            swap_pos_q   = RST_SWAP_POS;
            zero_high_q  = RST_ZERO_HIGH;
            one_high_q   = RST_ONE_HIGH;
            period_q     = RST_BIT_PERIOD;
            position_q   = 8'd0;
            owed_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                check_symbol();
                symbols_seen++;
            end
            if (push && !full)
                predict_led(red, green, blue, frame_end);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BRIGHTNESS: brightness_q = cfg_data;
                    REG_SWAP_POS:   swap_pos_q   = cfg_data;
                    REG_ZERO_HIGH:  zero_high_q  = cfg_data;
                    REG_ONE_HIGH:   one_high_q   = cfg_data;
                    REG_BIT_PERIOD: period_q     = cfg_data;
                    default: ;  // unused index, dropped
                endcase
            end
        end
        symbols_owed = owed_q.size();
    end

    always @(posedge closing)
    begin
        if (owed_q.size() != 0)
            report($sformatf("%0d symbols never arrived", owed_q.size()));
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip serialiser testbench
// Sends LED colours through the push/full side under a series of register
// settings, pops the pulse symbols at random, and leaves the checking to the
// symbol checker alongside the block. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module testbench;
    import rlss_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int IDLE_PERCENT    = 24;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int RX_HOLD_CYCLES  = 400;   // long enough to fill both queues
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 4000;  // cycles with no handshake at all
    localparam logic [CFG_IDX_W-1:0] LAST_INDEX = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 frame_end;
    logic                 pop;
    logic                 empty;
    logic                 bit_value;
    logic [7:0]           high_ticks;
    logic [7:0]           low_ticks;
    logic                 last_of_led;
    logic                 frame_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 closing;

    int mismatches;
    int symbols_owed;
    int symbols_seen;
    int leds_sent;
    int settings_applied;
    int quiet_cycles;

    // shared between the sender and the receiver
    bit steady_flow;    // no idling on either side while set
    bit hold_request;   // sender asks the receiver for a long hold-off

    rgb_led_strip_serializer #(
        .LED_SLOTS(DEFAULT_LED_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .red(red),
        .green(green),
        .blue(blue),
        .frame_end(frame_end),
        .pop(pop),
        .empty(empty),
        .bit_value(bit_value),
        .high_ticks(high_ticks),
        .low_ticks(low_ticks),
        .last_of_led(last_of_led),
        .frame_done(frame_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    led_symbol_checker #(
        .SLOTS(DEFAULT_LED_SLOTS)
    ) symbol_check (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .red(red),
        .green(green),
        .blue(blue),
        .frame_end(frame_end),
        .pop(pop),
        .empty(empty),
        .bit_value(bit_value),
        .high_ticks(high_ticks),
        .low_ticks(low_ticks),
        .last_of_led(last_of_led),
        .frame_done(frame_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .closing(closing),
        .mismatches(mismatches),
        .symbols_owed(symbols_owed),
        .symbols_seen(symbols_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: any handshake on any channel counts as progress. The longest
    // honest silence is the receiver hold-off with the input already full.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: no progress for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: pops at random, steadily while steady_flow is set, and once
    // holds off for RX_HOLD_CYCLES so that the block backs up into full.
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (steady_flow)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offer one LED; returns at the edge where it was taken, push still high
    // so a following item goes out back to back.
    task automatic offer_led(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic fe);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        frame_end <= fe;
        @(posedge clk);
        while (full)
            @(posedge clk);
        leds_sent++;
    endtask

    // Sender stops and waits until every owed symbol has been popped.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (symbols_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers, optionally followed by a write to an unused
    // index that must leave everything as it was.
    task automatic apply_settings(input logic [7:0] bright, input logic [7:0] swap,
                                  input logic [7:0] zero_hi, input logic [7:0] one_hi,
                                  input logic [7:0] period, input bit add_unused);
        logic [CFG_IDX_W-1:0] idx[5];
        logic [7:0]           val[5];
        idx = '{REG_BRIGHTNESS, REG_SWAP_POS, REG_ZERO_HIGH, REG_ONE_HIGH, REG_BIT_PERIOD};
        val = '{bright, swap, zero_hi, one_hi, period};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        if (add_unused)
        begin
            cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_BIT_PERIOD) + 1, int'(LAST_INDEX)));
            cfg_data  <= 8'($urandom_range(0, 255));
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly realistic bit times, now and then the extremes
    function automatic logic [7:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [7:0] pick_brightness();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1, 2:    return 8'd255;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    initial
    begin
        int sent;
        int frame_len;
        clk              = 1'b0;
        rst_n            = 1'b0;
        push             = 1'b0;
        red              = 8'd0;
        green            = 8'd0;
        blue             = 8'd0;
        frame_end        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_BRIGHTNESS;
        cfg_data         = 8'd0;
        closing          = 1'b0;
        steady_flow      = 1'b0;
        hold_request     = 1'b0;
        leds_sent        = 0;
        settings_applied = 0;
        quiet_cycles     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full brightness loses one on nonzero bytes, and
        // the LED at position 1 gets red and green exchanged.
        offer_led(8'd0,   8'd0,   8'd0,   1'b0);
        offer_led(8'd255, 8'd0,   8'h81,  1'b0);   // swapped slot
        offer_led(8'h80,  8'h01,  8'h7F,  1'b0);
        offer_led(8'hAA,  8'h55,  8'hFF,  1'b1);   // frame end, position back to 0
        offer_led(8'h12,  8'hC3,  8'h3C,  1'b0);
        offer_led(8'hF0,  8'h0F,  8'h99,  1'b1);   // swapped slot again, after restart
        drain();

        // Everything at the bottom: black output, zero high time, zero period.
        apply_settings(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1);
        offer_led(8'd255, 8'd255, 8'd255, 1'b0);
        offer_led(8'h5A,  8'hA5,  8'h01,  1'b1);
        drain();

        // Top of the ranges: high time of a zero bit fills the whole period
        // so low time saturates; swap slot far beyond the strip.
        apply_settings(8'd128, 8'd200, 8'd255, 8'd1, 8'd255, 1'b1);
        offer_led(8'd255, 8'd128, 8'd1,   1'b0);
        offer_led(8'h7E,  8'hE7,  8'hFF,  1'b0);
        offer_led(8'hCC,  8'h33,  8'h80,  1'b1);
        drain();

        // Random part: frames of random length, some longer than the strip so
        // the position wraps; the last frame of a phase may be cut short and
        // carry on under the next setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_settings(pick_brightness(),
                           ($urandom_range(0, 9) == 0) ? 8'd255
                                                       : 8'($urandom_range(0, 17)),
                           pick_ticks(), pick_ticks(),
                           ($urandom_range(0, 4) == 0) ? pick_ticks()
                                                       : 8'($urandom_range(20, 60)),
                           $urandom_range(0, 2) == 0);
            steady_flow = (phase == 1);
            if (phase == 2)
                hold_request = 1'b1;    // receiver stalls, sender keeps pushing
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24)
                                                        : $urandom_range(1, 8);
                for (int k = 0; k < frame_len && sent < ITEMS_PER_PHASE; k++)
                begin
                    offer_led(pick_channel(), pick_channel(), pick_channel(),
                              k == frame_len - 1);
                    sent++;
                end
            end
            drain();
            steady_flow = 1'b0;
        end

        // let any stray symbol show up before the books are closed
        repeat (40) @(posedge clk);
        closing <= 1'b1;
        @(posedge clk);
        @(posedge clk);

        $display("testbench: %0d LEDs sent, %0d symbols checked, %0d register settings",
                 leds_sent, symbols_seen, settings_applied);
        $display("testbench: covered extremes, swap slot, wrap past the strip, backpressure");
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: rgb_led_strip_serializer.f
+incdir+rtl
rtl/rlss_pkg.sv
rtl/rlss_front.sv
rtl/rlss_queue.sv
rtl/rlss_back.sv
rtl/rgb_led_strip_serializer.sv
tb/sv/led_symbol_checker.sv
tb/sv/testbench.sv
